### hw/rtl/pfd_pkg.sv
package pfd_pkg;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SYNC_THRESHOLD = 3'd0,
      CSR_MIN_WIDTH      = 3'd1,
      CSR_MAX_WIDTH      = 3'd2,
      CSR_DEADBAND       = 3'd3,
      CSR_INVERT_MASK    = 3'd4,
      CSR_SLIDER_MASK    = 3'd5
   } csr_index_type;

   localparam logic [15:0] SYNC_THRESHOLD_RST = 16'd2700;
   localparam logic [11:0] MIN_WIDTH_RST      = 12'd900;
   localparam logic [11:0] MAX_WIDTH_RST      = 12'd2100;
   localparam logic [8:0]  DEADBAND_RST       = 9'd20;
   localparam logic [7:0]  INVERT_MASK_RST    = 8'd6;
   localparam logic [7:0]  SLIDER_MASK_RST    = 8'd48;

   localparam logic [11:0] WIDTH_RST = 12'd1500;

   localparam logic signed [13:0] CENTRE_US      = 14'sd1500;
   localparam logic signed [13:0] HALF_SPAN_US   = 14'sd500;
   localparam logic signed [13:0] SLIDER_BASE_US = 14'sd1000;
   localparam logic signed [16:0] AXIS_GAIN      = 17'sd65534;
   localparam logic signed [16:0] SLIDER_GAIN    = 17'sd32767;
   localparam logic signed [22:0] AXIS_OFFSET    = 23'sd32767;
   localparam logic signed [22:0] AXIS_LIMIT     = 23'sd32767;

   // ceil(2^38 / 1000): exact floor division by 1000 for operands below 2^30
   localparam logic [28:0] RECIP_1000 = 29'd274877907;
   localparam int unsigned RECIP_SHIFT = 38;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL1,
      ST_MUL2,
      ST_MAP,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic capture;
      logic store;
      logic clear_pos;
      logic first_chan;
      logic next_chan;
      logic mul1;
      logic mul2;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic is_sync;
      logic have_chan;
      logic last_chan;
   } status_type;

endpackage

### hw/rtl/ppm_frame_decoder_axis_map_unit.sv
// Channel | Direction | Transfer content
// req     | in        | tdata[31:0] edge_time_us
// rsp     | out       | tdata[2:0] channel, [14:3] raw_width_us, [30:15] axis_value;
//         |           | tlast last_in_frame
// csr     | in        | write enable, register index, 16-bit write data
// An edge is handled as transfer, then interval check and channel store.
// At a frame end with captured channels, each channel in turn passes the gain multiplier,
// the divide-by-1000 reciprocal multiplier and the clamp, and is then sent.
// Reset is synchronous and restores registers, widths (1500) and position.
// A stalled result holds the sequencer; req_tready stays low until the frame is sent.
module ppm_frame_decoder_axis_map_unit #(
   parameter int unsigned NUM_CHANNELS = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,  // edge_time_us
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,  // channel, raw_width_us, axis_value
   output logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [pfd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [pfd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   pfd_pkg::cmd_type    cmd;
   pfd_pkg::status_type status;
   logic [2:0]          channel;
   logic [11:0]         raw_width_us;
   logic signed [15:0]  axis_value;
   logic                last_in_frame;

   pfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pfd_dp #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .edge_time_us  (req_tdata),
      .cmd           (cmd),
      .status        (status),
      .channel       (channel),
      .raw_width_us  (raw_width_us),
      .axis_value    (axis_value),
      .last_in_frame (last_in_frame)
   );

   assign rsp_tdata = {1'b0, axis_value, raw_width_us, channel};
   assign rsp_tlast = last_in_frame;

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while a result is pending");

   a_frame_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("no return to idle after last transfer");

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[30:15] != 16'h8000)
      else $error("axis value out of range");

   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[2:0]) < NUM_CHANNELS)
      else $error("channel index out of range");

endmodule

### hw/rtl/pfd_ctrl.sv
module pfd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  pfd_pkg::status_type status,
   output pfd_pkg::cmd_type    cmd
);

   pfd_pkg::state_type state_ff;
   pfd_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         pfd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = pfd_pkg::ST_EVAL;
            end
         end
         pfd_pkg::ST_EVAL: begin
            if (status.is_sync) begin
               cmd.clear_pos = 1'b1;
               if (status.have_chan) begin
                  cmd.first_chan = 1'b1;
                  state_in       = pfd_pkg::ST_MUL1;
               end else begin
                  state_in = pfd_pkg::ST_IDLE;
               end
            end else begin
               cmd.store = 1'b1;
               state_in  = pfd_pkg::ST_IDLE;
            end
         end
         pfd_pkg::ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = pfd_pkg::ST_MUL2;
         end
         pfd_pkg::ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = pfd_pkg::ST_MAP;
         end
         pfd_pkg::ST_MAP: begin
            cmd.load_out = 1'b1;
            state_in     = pfd_pkg::ST_SEND;
         end
         pfd_pkg::ST_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (status.last_chan) begin
                  state_in = pfd_pkg::ST_IDLE;
               end else begin
                  cmd.next_chan = 1'b1;
                  state_in      = pfd_pkg::ST_MUL1;
               end
            end
         end
         default: begin
            state_in = pfd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/pfd_dp.sv
module pfd_dp #(
   parameter int unsigned NUM_CHANNELS = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [pfd_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [pfd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [31:0]                        edge_time_us,
   input  pfd_pkg::cmd_type                   cmd,
   output pfd_pkg::status_type                status,
   output logic [2:0]                         channel,
   output logic [11:0]                        raw_width_us,
   output logic signed [15:0]                 axis_value,
   output logic                               last_in_frame
);

   localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int unsigned POS_W = $clog2(NUM_CHANNELS + 1);

   logic [15:0] sync_threshold_ff;
   logic [11:0] min_width_ff;
   logic [11:0] max_width_ff;
   logic [8:0]  deadband_ff;
   logic [7:0]  invert_mask_ff;
   logic [7:0]  slider_mask_ff;

   logic [31:0]      prev_time_ff;
   logic [31:0]      pulse_ff;
   logic [POS_W-1:0] pos_ff;
   logic [2:0]       idx_ff;
   logic [11:0]      widths_ff [NUM_CHANNELS];

   logic [11:0]        wsel_ff;
   logic               slider_ff;
   logic               invert_ff;
   logic signed [30:0] prod1_ff;
   logic [58:0]        prod2_ff;
   logic               neg_ff;
   logic [11:0]        width_out_ff;
   logic signed [15:0] axis_out_ff;

   logic [11:0]        wsel;
   logic               sel_slider;
   logic signed [13:0] c_s;
   logic [13:0]        c_mag;
   logic signed [13:0] t_s;
   logic signed [16:0] k_s;
   logic signed [30:0] prod1_in;
   logic [30:0]        mag;
   logic [58:0]        prod2_in;
   logic [20:0]        quot;
   logic signed [22:0] v_s;
   logic signed [22:0] v_clamp;
   logic signed [15:0] axis_in;
   logic [11:0]        clamped_width;
   logic               pos_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_threshold_ff <= pfd_pkg::SYNC_THRESHOLD_RST;
         min_width_ff      <= pfd_pkg::MIN_WIDTH_RST;
         max_width_ff      <= pfd_pkg::MAX_WIDTH_RST;
         deadband_ff       <= pfd_pkg::DEADBAND_RST;
         invert_mask_ff    <= pfd_pkg::INVERT_MASK_RST;
         slider_mask_ff    <= pfd_pkg::SLIDER_MASK_RST;
      end else if (csr_we) begin
         case (csr_addr)
            pfd_pkg::CSR_SYNC_THRESHOLD: sync_threshold_ff <= csr_wdata;
            pfd_pkg::CSR_MIN_WIDTH:      min_width_ff      <= csr_wdata[11:0];
            pfd_pkg::CSR_MAX_WIDTH:      max_width_ff      <= csr_wdata[11:0];
            pfd_pkg::CSR_DEADBAND:       deadband_ff       <= csr_wdata[8:0];
            pfd_pkg::CSR_INVERT_MASK:    invert_mask_ff    <= csr_wdata[7:0];
            pfd_pkg::CSR_SLIDER_MASK:    slider_mask_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign pos_full = (pos_ff >= POS_W'(NUM_CHANNELS));

   always_comb begin
      if (pulse_ff < {20'd0, min_width_ff}) begin
         clamped_width = min_width_ff;
      end else if (pulse_ff > {20'd0, max_width_ff}) begin
         clamped_width = max_width_ff;
      end else begin
         clamped_width = pulse_ff[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
         pos_ff       <= '0;
         idx_ff       <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            widths_ff[i] <= pfd_pkg::WIDTH_RST;
         end
      end else begin
         if (cmd.capture) begin
            prev_time_ff <= edge_time_us;
         end
         if (cmd.clear_pos) begin
            pos_ff <= '0;
         end else if (cmd.store && !pos_full) begin
            widths_ff[pos_ff[IDX_W-1:0]] <= clamped_width;
            pos_ff                       <= pos_ff + POS_W'(1);
         end
         if (cmd.first_chan) begin
            idx_ff <= '0;
         end else if (cmd.next_chan) begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pulse_ff <= edge_time_us - prev_time_ff;
      end
   end

   assign status.is_sync   = (pulse_ff > {16'd0, sync_threshold_ff});
   assign status.have_chan = (pos_ff != '0);
   assign status.last_chan = (idx_ff == 3'(NUM_CHANNELS - 1));

   assign wsel       = widths_ff[idx_ff[IDX_W-1:0]];
   assign sel_slider = slider_mask_ff[idx_ff];

   always_comb begin
      c_s   = $signed({2'b00, wsel}) - pfd_pkg::CENTRE_US;
      c_mag = c_s[13] ? 14'(-c_s) : 14'(c_s);
      if (sel_slider) begin
         t_s = $signed({2'b00, wsel}) - pfd_pkg::SLIDER_BASE_US;
         k_s = pfd_pkg::SLIDER_GAIN;
      end else begin
         if (c_mag <= {5'd0, deadband_ff}) begin
            t_s = pfd_pkg::HALF_SPAN_US;
         end else begin
            t_s = c_s + pfd_pkg::HALF_SPAN_US;
         end
         k_s = pfd_pkg::AXIS_GAIN;
      end
      prod1_in = 31'(t_s) * 31'(k_s);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         prod1_ff  <= prod1_in;
         wsel_ff   <= wsel;
         slider_ff <= sel_slider;
         invert_ff <= invert_mask_ff[idx_ff];
      end
   end

   always_comb begin
      mag      = prod1_ff[30] ? 31'(-prod1_ff) : 31'(prod1_ff);
      prod2_in = 59'(mag[29:0]) * 59'(pfd_pkg::RECIP_1000);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul2) begin
         prod2_ff <= prod2_in;
         neg_ff   <= prod1_ff[30];
      end
   end

   always_comb begin
      quot = prod2_ff[58:pfd_pkg::RECIP_SHIFT];
      v_s  = neg_ff ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
      if (!slider_ff) begin
         v_s = v_s - pfd_pkg::AXIS_OFFSET;
      end
      if (v_s > pfd_pkg::AXIS_LIMIT) begin
         v_clamp = pfd_pkg::AXIS_LIMIT;
      end else if (v_s < -pfd_pkg::AXIS_LIMIT) begin
         v_clamp = -pfd_pkg::AXIS_LIMIT;
      end else begin
         v_clamp = v_s;
      end
      if (!slider_ff && invert_ff) begin
         axis_in = 16'(-v_clamp);
      end else begin
         axis_in = 16'(v_clamp);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         width_out_ff <= wsel_ff;
         axis_out_ff  <= axis_in;
      end
   end

   assign channel       = idx_ff;
   assign raw_width_us  = width_out_ff;
   assign axis_value    = axis_out_ff;
   assign last_in_frame = status.last_chan;

endmodule

### verif/tb_ppm_frame_decoder_axis_map_unit.sv
module tb_ppm_frame_decoder_axis_map_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CH        = 6;
   localparam int SETTLE_CYCLES = 2 + 4 * NUM_CH + 6;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 12;

   localparam logic [pfd_pkg::CSR_ADDR_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [pfd_pkg::CSR_ADDR_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum logic {ROW_EDGE, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [2:0]            reg_index;
      logic [31:0]           value;
      logic                  typed;
      logic [11:0]           raw0;
      logic signed [15:0]    axis0;
   } plan_row_type;

   typedef struct packed {
      logic [2:0]         channel;
      logic [11:0]        raw_us;
      logic signed [15:0] axis;
      logic               last;
   } frame_result_type;

   localparam int PLAN_LEN = 36;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd1000,      1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd7000,      1'b1, 12'd1000, -16'sd32767},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd10000,     1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd10100,     1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd12600,     1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd14100,     1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd15620,     1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd17141,     1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd18141,     1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd20141,     1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd22841,     1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd25542,     1'b1, 12'd900,  -16'sd32767},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'hFFFF_FFFF, 1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd999,       1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd0,         1'b1, 12'd1000, -16'sd32767},
      '{ROW_WRITE, pfd_pkg::CSR_MIN_WIDTH,      32'd1200,      1'b0, 12'd0,    16'sd0},
      '{ROW_WRITE, pfd_pkg::CSR_MAX_WIDTH,      32'd1100,      1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd500,       1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd1700,      1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd10000,     1'b1, 12'd1200, -16'sd19661},
      '{ROW_WRITE, CSR_SPARE_LO,                32'h0000_FFFF, 1'b0, 12'd0,    16'sd0},
      '{ROW_WRITE, CSR_SPARE_HI,                32'd0,         1'b0, 12'd0,    16'sd0},
      '{ROW_WRITE, pfd_pkg::CSR_DEADBAND,       32'h0000_FFFF, 1'b0, 12'd0,    16'sd0},
      '{ROW_WRITE, pfd_pkg::CSR_SYNC_THRESHOLD, 32'h0000_FFFF, 1'b0, 12'd0,    16'sd0},
      '{ROW_WRITE, pfd_pkg::CSR_MIN_WIDTH,      32'd0,         1'b0, 12'd0,    16'sd0},
      '{ROW_WRITE, pfd_pkg::CSR_MAX_WIDTH,      32'h0000_FFFF, 1'b0, 12'd0,    16'sd0},
      '{ROW_WRITE, pfd_pkg::CSR_INVERT_MASK,    32'h0000_00FF, 1'b0, 12'd0,    16'sd0},
      '{ROW_WRITE, pfd_pkg::CSR_SLIDER_MASK,    32'd0,         1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd14095,     1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd79631,     1'b1, 12'd4095, -16'sd32767},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd79631,     1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd81131,     1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd146667,    1'b1, 12'd0,    16'sd32767},
      '{ROW_WRITE, pfd_pkg::CSR_SLIDER_MASK,    32'h0000_00FF, 1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd146667,    1'b0, 12'd0,    16'sd0},
      '{ROW_EDGE,  pfd_pkg::CSR_SYNC_THRESHOLD, 32'd212203,    1'b1, 12'd0,    -16'sd32767}
   };

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [31:0]                    req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b1;
   logic [31:0]                    rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_we     = 1'b0;
   logic [pfd_pkg::CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [pfd_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   int idle_pct    = 0;
   int stall_pct   = 0;
   int error_count = 0;

   // decoder image: registers, last edge, channel slot and held widths
   logic [15:0] gap_sync_us        = pfd_pkg::SYNC_THRESHOLD_RST;
   logic [11:0] width_floor_us     = pfd_pkg::MIN_WIDTH_RST;
   logic [11:0] width_ceil_us      = pfd_pkg::MAX_WIDTH_RST;
   logic [8:0]  centre_deadband_us = pfd_pkg::DEADBAND_RST;
   logic [7:0]  invert_bits        = pfd_pkg::INVERT_MASK_RST;
   logic [7:0]  slider_bits        = pfd_pkg::SLIDER_MASK_RST;
   logic [31:0] prev_edge_us       = '0;
   logic [3:0]  next_slot          = '0;
   logic [11:0] held_width [NUM_CH] = '{default: pfd_pkg::WIDTH_RST};

   frame_result_type burst [NUM_CH];
   frame_result_type results_due [$];

   ppm_frame_decoder_axis_map_unit #(
      .NUM_CHANNELS(NUM_CH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),   // [31:0] edge_time_us
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),   // [2:0] channel, [14:3] raw_width_us, [30:15] axis_value
      .rsp_tlast (rsp_tlast),   // last_in_frame
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic signed [15:0] axis_for(input int ch, input logic [11:0] w);
      longint c;
      longint v;
      if (slider_bits[ch]) begin
         v = (longint'(w) - 1000) * 32767 / 1000;
      end else begin
         c = longint'(w) - 1500;
         if ((c < 0 ? -c : c) <= longint'(centre_deadband_us)) c = 0;
         v = (c + 500) * 65534 / 1000 - 32767;
      end
      if (v < -32767) v = -32767;
      else if (v > 32767) v = 32767;
      if (!slider_bits[ch] && invert_bits[ch]) v = -v;
      return 16'(v);
   endfunction

   function automatic int decode_edge(input logic [31:0] t);
      logic [31:0] gap;
      logic [11:0] w;
      int          n;
      gap          = t - prev_edge_us;
      prev_edge_us = t;
      n            = 0;
      if (gap > {16'd0, gap_sync_us}) begin
         if (next_slot != 0) begin
            for (int i = 0; i < NUM_CH; i++) begin
               burst[i].channel = 3'(i);
               burst[i].raw_us  = held_width[i];
               burst[i].axis    = axis_for(i, held_width[i]);
               burst[i].last    = (i == NUM_CH - 1);
            end
            n = NUM_CH;
         end
         next_slot = '0;
      end else if (next_slot < NUM_CH) begin
         if (gap < {20'd0, width_floor_us}) w = width_floor_us;
         else if (gap > {20'd0, width_ceil_us}) w = width_ceil_us;
         else w = gap[11:0];
         held_width[next_slot[2:0]] = w;
         next_slot = next_slot + 4'd1;
      end
      return n;
   endfunction

   function automatic void compare_field(input string name, input longint want,
                                         input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (results_due.size() == 0) begin
            $error("unexpected transfer: channel %0d, tdata %h", rsp_tdata[2:0], rsp_tdata);
            error_count++;
         end else begin
            want = results_due.pop_front();
            compare_field("channel",       want.channel, rsp_tdata[2:0]);
            compare_field("raw_width_us",  want.raw_us,  rsp_tdata[14:3]);
            compare_field("axis_value",    want.axis,    $signed(rsp_tdata[30:15]));
            compare_field("last_in_frame", want.last,    rsp_tlast);
            compare_field("tdata padding", 0,            rsp_tdata[31]);
         end
      end
   end

   task automatic send_edge(input logic [31:0] t, input logic typed,
                            input logic [11:0] raw0, input logic signed [15:0] axis0);
      int n;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      do @(posedge clock); while (!req_tready);
      n = decode_edge(t);
      if (typed && n != 0) begin
         burst[0].raw_us = raw0;
         burst[0].axis   = axis0;
      end
      for (int i = 0; i < n; i++) results_due.push_back(burst[i]);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [pfd_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [15:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      case (idx)
         pfd_pkg::CSR_SYNC_THRESHOLD: gap_sync_us        = v;
         pfd_pkg::CSR_MIN_WIDTH:      width_floor_us     = v[11:0];
         pfd_pkg::CSR_MAX_WIDTH:      width_ceil_us      = v[11:0];
         pfd_pkg::CSR_DEADBAND:       centre_deadband_us = v[8:0];
         pfd_pkg::CSR_INVERT_MASK:    invert_bits        = v[7:0];
         pfd_pkg::CSR_SLIDER_MASK:    slider_bits        = v[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // drop valid, drain the frame queue, then let the sequencer go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_phase(input int mode, input int items);
      int          sent;
      int          k;
      int          lo;
      int          hi;
      logic [31:0] gap;
      case (mode)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 63; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 63; end
         default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(99) < 80) begin
            k = $urandom_range(0, 8);
            for (int i = 0; i < k; i++) begin
               lo = width_floor_us;
               hi = (width_ceil_us > gap_sync_us) ? gap_sync_us : width_ceil_us;
               if ($urandom_range(99) < 70 && lo <= hi) gap = $urandom_range(hi, lo);
               else gap = $urandom_range(gap_sync_us, 0);
               send_edge(prev_edge_us + gap, 1'b0, '0, '0);
            end
            case ($urandom_range(9))
               0: gap = gap_sync_us + 32'd1;
               1: gap = {16'($urandom_range(16'hFFFF, 1)), 16'($urandom)};
               default: gap = gap_sync_us + 32'd1 + $urandom_range(3000, 0);
            endcase
            send_edge(prev_edge_us + gap, 1'b0, '0, '0);
            sent += k + 1;
         end else begin
            send_edge($urandom, 1'b0, '0, '0);
            sent++;
         end
      end
   endtask

   initial begin
      logic [15:0] thr;
      logic [15:0] mn;
      logic [15:0] mx;
      logic [15:0] db;
      logic [15:0] inv;
      logic [15:0] sl;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < PLAN_LEN; r++) begin
         if (PLAN[r].kind == ROW_WRITE) begin
            settle();
            write_reg(PLAN[r].reg_index, PLAN[r].value[15:0]);
         end else begin
            send_edge(PLAN[r].value, PLAN[r].typed, PLAN[r].raw0, PLAN[r].axis0);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: begin
               thr = pfd_pkg::SYNC_THRESHOLD_RST;
               mn  = 16'(pfd_pkg::MIN_WIDTH_RST);
               mx  = 16'(pfd_pkg::MAX_WIDTH_RST);
               db  = 16'(pfd_pkg::DEADBAND_RST);
               inv = 16'(pfd_pkg::INVERT_MASK_RST);
               sl  = 16'(pfd_pkg::SLIDER_MASK_RST);
            end
            1: begin
               thr = '0; mn = '0; mx = '0; db = '0; inv = '0; sl = '0;
            end
            2: begin
               thr = '1; mn = '1; mx = '1; db = '1; inv = '1; sl = '1;
            end
            4, 6: begin
               thr = 16'($urandom_range(16'hFFFF, 0)); mn = 16'($urandom_range(16'hFFFF, 0));
               mx  = 16'($urandom_range(16'hFFFF, 0)); db = 16'($urandom_range(16'hFFFF, 0));
               inv = 16'($urandom_range(16'hFFFF, 0)); sl = 16'($urandom_range(16'hFFFF, 0));
            end
            default: begin
               thr = 16'($urandom_range(4000, 2200)); mn = 16'($urandom_range(1100, 800));
               mx  = 16'($urandom_range(2200, 1900)); db = 16'($urandom_range(60, 0));
               inv = 16'($urandom_range(255, 0));     sl = 16'($urandom_range(255, 0));
            end
         endcase
         write_reg(pfd_pkg::CSR_SYNC_THRESHOLD, thr);
         write_reg(pfd_pkg::CSR_MIN_WIDTH,      mn);
         write_reg(pfd_pkg::CSR_MAX_WIDTH,      mx);
         write_reg(pfd_pkg::CSR_DEADBAND,       db);
         write_reg(pfd_pkg::CSR_INVERT_MASK,    inv);
         write_reg(pfd_pkg::CSR_SLIDER_MASK,    sl);
         run_phase(p % 4, PHASE_ITEMS);
      end

      settle();
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### files.f
hw/rtl/pfd_pkg.sv
hw/rtl/pfd_ctrl.sv
hw/rtl/pfd_dp.sv
hw/rtl/ppm_frame_decoder_axis_map_unit.sv
verif/tb_ppm_frame_decoder_axis_map_unit.sv
